>>> hw/rtl/ffha_pkg.sv
// Package for the first-fit heap allocator.
// Holds heap geometry, header widths, command and status codes.
// No dependencies.
`default_nettype none
package ffha_pkg;
	localparam int PAGE_BYTES = 4096;
	localparam int HEAP_BYTES = 65536;
	localparam int HDR_BYTES  = 4;
	localparam int STORE_DEPTH = HEAP_BYTES / HDR_BYTES;
	localparam int IDX_W      = $clog2(STORE_DEPTH);
	localparam int HDR_W      = 17;
	localparam int OFF_W      = 17;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int PAGE_CAP   = HEAP_BYTES / PAGE_BYTES;
	localparam int PG_W       = 5;

	localparam logic [HDR_W-1:0] HDR_INC   = HDR_W'(HDR_BYTES);
	localparam logic [HDR_W-1:0] PAGE_INC  = HDR_W'(PAGE_BYTES);
	localparam logic [HDR_W-1:0] PAGE_FREE = HDR_W'(PAGE_BYTES - HDR_BYTES);
	localparam logic [PG_W-1:0]  PG_CAP    = PG_W'(PAGE_CAP);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_NOTUSED = 2'd2;
endpackage
`default_nettype wire

>>> hw/rtl/ffha_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One access a cycle: write, or read with data in the next cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: request sequencer and header store.
// Depends on ffha_pkg and ffha_ram.
//
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             cmd, request_size, payload_offset
// result    out        done (one-cycle strobe)   status, block_offset
// config    in         cfg_we                    cfg_wdata (max_pages)
//
// A request reads each block header in a check state that drives the address, then an
// evaluate state; each page mapped, merge write-back and second header of a split is
// one more RAM write, as the single header RAM port allows one access at a time.
// Done is registered from the last state; a null free or short offset ends from idle.
// After reset the block takes requests at once; the first header reads as one
// free page until it is first written. The receiver cannot stall results.
`default_nettype none
module first_fit_heap_allocator
	import ffha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cmd,
	input  wire logic [16:0] request_size,
	input  wire logic [15:0] payload_offset,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      block_offset,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata
);
	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_A_CHK  = 10'b0000000010,
		S_A_EVAL = 10'b0000000100,
		S_A_SPLT = 10'b0000001000,
		S_R_CHK  = 10'b0000010000,
		S_R_EVAL = 10'b0000100000,
		S_R_END  = 10'b0001000000,
		S_F_CHK  = 10'b0010000000,
		S_F_EVAL = 10'b0100000000,
		S_F_HDR  = 10'b1000000000
	} state_t;

	state_t            state_q, state_d;
	logic [OFF_W-1:0]  n_q, n_d, nx_q, nx_d, lf_q, lf_d;
	logic [HDR_W-1:0]  h_q, h_d, lf_h_q, lf_h_d, total_q, total_d;
	logic              have_free_q, have_free_d, cmd_q, cmd_d;
	logic [17:0]       need_q, need_d;
	logic [15:0]       target_q, target_d;
	logic [PG_W-1:0]   pages_q, pages_d, max_pages_q, limit;
	logic              hdr0_vld_q, rd_dflt_s1;
	logic              done_q, done_d;
	logic [1:0]        status_q, status_d;
	logic [15:0]       boff_q, boff_d;
	logic              ram_we;
	logic [OFF_W-1:0]  ram_off;
	logic [HDR_W-1:0]  ram_wdata, ram_rdata, hdr;
	logic [OFF_W-1:0]  top;
	logic [HDR_W-1:0]  hclr;
	logic [18:0]       need_hdr;

	assign top      = {pages_q, {PAGE_SHIFT{1'b0}}};
	assign limit    = (max_pages_q < PG_CAP) ? max_pages_q : PG_CAP;
	assign hdr      = rd_dflt_s1 ? PAGE_FREE : ram_rdata;
	assign hclr     = {hdr[HDR_W-1:1], 1'b0};
	assign need_hdr = {1'b0, need_q} + 19'(HDR_BYTES);
	assign busy     = (state_q != S_IDLE);

	ffha_ram #(.WIDTH(HDR_W), .DEPTH(STORE_DEPTH)) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_off[IDX_W+1:2]),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Next-state, datapath and RAM port control.
	always_comb begin
		state_d     = state_q;
		n_d         = n_q;
		nx_d        = nx_q;
		lf_d        = lf_q;
		h_d         = h_q;
		lf_h_d      = lf_h_q;
		total_d     = total_q;
		have_free_d = have_free_q;
		cmd_d       = cmd_q;
		need_d      = need_q;
		target_d    = target_q;
		pages_d     = pages_q;
		done_d      = 1'b0;
		status_d    = status_q;
		boff_d      = boff_q;
		ram_we      = 1'b0;
		ram_off     = '0;
		ram_wdata   = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_d = cmd;
					if (cmd == CMD_ALLOC) begin
						need_d      = ({1'b0, request_size} + 18'd7) & ~18'd7;
						n_d         = '0;
						have_free_d = 1'b0;
						state_d     = S_A_CHK;
					end else if (payload_offset == 16'd0) begin
						done_d   = 1'b1;
						status_d = ST_OK;
						boff_d   = '0;
					end else if (payload_offset < 16'(HDR_BYTES)) begin
						done_d   = 1'b1;
						status_d = ST_NOTUSED;
						boff_d   = '0;
					end else begin
						target_d = payload_offset - 16'(HDR_BYTES);
						n_d      = '0;
						state_d  = S_F_CHK;
					end
				end
			end
			// Reached the mapped top: map a page or give up; else read the header.
			S_A_CHK: begin
				if (n_q >= top) begin
					if (pages_q >= limit) begin
						done_d   = 1'b1;
						status_d = ST_NOMEM;
						boff_d   = '0;
						state_d  = S_IDLE;
					end else begin
						pages_d = pages_q + 1'b1;
						ram_we  = 1'b1;
						if (have_free_q) begin
							ram_off   = lf_q;
							ram_wdata = lf_h_q + PAGE_INC;
							n_d       = lf_q;
						end else begin
							ram_off   = n_q;
							ram_wdata = PAGE_FREE;
						end
					end
				end else begin
					ram_off = n_q;
					state_d = S_A_EVAL;
				end
			end
			S_A_EVAL: begin
				if (hdr[0]) begin
					n_d         = n_q + HDR_INC + hclr;
					have_free_d = 1'b0;
					state_d     = S_A_CHK;
				end else if ({2'b0, hdr} >= need_hdr) begin
					ram_we    = 1'b1;
					ram_off   = n_q + HDR_INC + need_q[OFF_W-1:0];
					ram_wdata = hdr - need_q[HDR_W-1:0] - HDR_INC;
					state_d   = S_A_SPLT;
				end else if ({1'b0, hdr} >= need_q) begin
					ram_we    = 1'b1;
					ram_off   = n_q;
					ram_wdata = hdr | HDR_W'(1);
					done_d    = 1'b1;
					status_d  = ST_OK;
					boff_d    = 16'(n_q + HDR_INC);
					state_d   = S_IDLE;
				end else begin
					h_d     = hdr;
					nx_d    = n_q + HDR_INC + hdr;
					total_d = '0;
					state_d = S_R_CHK;
				end
			end
			// Second write of a split: the chosen block's own header.
			S_A_SPLT: begin
				ram_we    = 1'b1;
				ram_off   = n_q;
				ram_wdata = need_q[HDR_W-1:0] | HDR_W'(1);
				done_d    = 1'b1;
				status_d  = ST_OK;
				boff_d    = 16'(n_q + HDR_INC);
				state_d   = S_IDLE;
			end
			// Walk the run of free blocks that follows block n.
			S_R_CHK: begin
				if (nx_q >= top) begin
					state_d = S_R_END;
				end else begin
					ram_off = nx_q;
					state_d = S_R_EVAL;
				end
			end
			S_R_EVAL: begin
				if (hdr[0]) begin
					state_d = S_R_END;
				end else begin
					total_d = total_q + HDR_INC + hdr;
					nx_d    = nx_q + HDR_INC + hdr;
					state_d = S_R_CHK;
				end
			end
			S_R_END: begin
				if (cmd_q == CMD_FREE) begin
					ram_we    = 1'b1;
					ram_off   = n_q;
					ram_wdata = h_q + total_q;
					done_d    = 1'b1;
					status_d  = ST_OK;
					boff_d    = '0;
					state_d   = S_IDLE;
				end else if (total_q != '0) begin
					ram_we    = 1'b1;
					ram_off   = n_q;
					ram_wdata = h_q + total_q;
					state_d   = S_A_CHK;
				end else begin
					lf_d        = n_q;
					lf_h_d      = h_q;
					have_free_d = 1'b1;
					n_d         = n_q + HDR_INC + h_q;
					state_d     = S_A_CHK;
				end
			end
			// Free: walk the chain up to the target header.
			S_F_CHK: begin
				if (n_q < top && n_q < {1'b0, target_q}) begin
					ram_off = n_q;
					state_d = S_F_EVAL;
				end else if (n_q == {1'b0, target_q} && n_q < top) begin
					ram_off = n_q;
					state_d = S_F_HDR;
				end else begin
					done_d   = 1'b1;
					status_d = ST_NOTUSED;
					boff_d   = '0;
					state_d  = S_IDLE;
				end
			end
			S_F_EVAL: begin
				n_d     = n_q + HDR_INC + hclr;
				state_d = S_F_CHK;
			end
			S_F_HDR: begin
				if (!hdr[0]) begin
					done_d   = 1'b1;
					status_d = ST_NOTUSED;
					boff_d   = '0;
					state_d  = S_IDLE;
				end else begin
					h_d     = hclr;
					nx_d    = n_q + HDR_INC + hclr;
					total_d = '0;
					state_d = S_R_CHK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pages_q     <= PG_W'(1);
			max_pages_q <= PG_CAP;
			hdr0_vld_q  <= 1'b0;
			rd_dflt_s1  <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q    <= state_d;
			pages_q    <= pages_d;
			done_q     <= done_d;
			rd_dflt_s1 <= !ram_we && ram_off == '0 && !hdr0_vld_q;
			if (ram_we && ram_off == '0) begin
				hdr0_vld_q <= 1'b1;
			end
			if (cfg_we) begin
				max_pages_q <= cfg_wdata;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		n_q         <= n_d;
		nx_q        <= nx_d;
		lf_q        <= lf_d;
		h_q         <= h_d;
		lf_h_q      <= lf_h_d;
		total_q     <= total_d;
		have_free_q <= have_free_d;
		cmd_q       <= cmd_d;
		need_q      <= need_d;
		target_q    <= target_d;
		status_q    <= status_d;
		boff_q      <= boff_d;
	end

	assign done         = done_q;
	assign status       = status_q;
	assign block_offset = boff_q;

`ifndef ASSERT_OFF
	a_pages_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pages_q <= PG_CAP && pages_q != '0)
		else $error("mapped page count out of range");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> block_offset == 16'd0)
		else $error("failed request returned an offset");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3)
		else $error("undefined status code");
	a_pages_grow: assert property (@(posedge clk) disable iff (!arst_n)
		pages_q != $past(pages_q) |-> $past(state_q) == S_A_CHK)
		else $error("page mapped outside the allocate walk");
`endif
endmodule
`default_nettype wire
